### rtl/core/four_register_alu_machine_top_defines.svh
// Assertion macros shared by the checker files of the four-register ALU machine.
`ifndef FOUR_REGISTER_ALU_MACHINE_TOP_DEFINES_SVH
`define FOUR_REGISTER_ALU_MACHINE_TOP_DEFINES_SVH

// Check a property on every rising clock edge, held off while reset is low.
`define FRAM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FRAM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/fram_pkg.sv
// Shared constants, command codes and control structs of the four-register ALU machine.
`timescale 1ns / 1ps

package fram_pkg;

  // Register width inside the machine (8..64).
  localparam int DATA_WIDTH = 64;

  // Fixed widths of the word fields.
  localparam int CMD_W = 3;
  localparam int REG_AW = 2;
  localparam int NUM_REGS = 4;
  localparam int IMM_W = 64;
  localparam int OUT_W = 64;

  // Step counter of the shift-and-add multiplier and the restoring divider.
  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd5;
  localparam logic [CMD_W-1:0] CMD_OUT = 3'd6;

  // Write-back source select.
  localparam int WSEL_W = 3;
  localparam logic [WSEL_W-1:0] WSEL_IMM = 3'd0;
  localparam logic [WSEL_W-1:0] WSEL_SRC = 3'd1;
  localparam logic [WSEL_W-1:0] WSEL_ADD = 3'd2;
  localparam logic [WSEL_W-1:0] WSEL_SUB = 3'd3;
  localparam logic [WSEL_W-1:0] WSEL_MUL = 3'd4;
  localparam logic [WSEL_W-1:0] WSEL_DIV = 3'd5;

  // Controller to datapath.
  typedef struct packed {
    logic              capture;
    logic              wr_en;
    logic [WSEL_W-1:0] wr_sel;
    logic              mul_init;
    logic              div_init;
    logic              mul_step;
    logic              div_step;
    logic              emit_val;
    logic              emit_err;
  } fram_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic src_zero;
  } fram_sts_t;

endpackage

### rtl/core/fram_if.sv
// Valid/ready channel interfaces for instruction words and result words.
`timescale 1ns / 1ps

interface fram_in_if;
  logic                                valid;
  logic                                ready;
  logic [fram_pkg::CMD_W-1:0]          command;
  logic [fram_pkg::REG_AW-1:0]         dest_reg;
  logic [fram_pkg::REG_AW-1:0]         src_reg;
  logic signed [fram_pkg::IMM_W-1:0]   immediate;

  modport source (output valid, command, dest_reg, src_reg, immediate, input ready);
  modport sink (input valid, command, dest_reg, src_reg, immediate, output ready);
endinterface

interface fram_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fram_pkg::OUT_W-1:0]   out_value;
  logic                                div_zero_error;

  modport source (output valid, out_value, div_zero_error, input ready);
  modport sink (input valid, out_value, div_zero_error, output ready);
endinterface

### rtl/core/fram_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps

module fram_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/core/fram_ctrl.sv
// Instruction sequencer of the four-register ALU machine.
`timescale 1ns / 1ps

module fram_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fram_pkg::CMD_W-1:0] in_command,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fram_pkg::fram_cmd_t        cmd,
  input  fram_pkg::fram_sts_t        sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_MUL = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_WB = 3'd5;

  logic [2:0]                       state_r, state_nxt;
  logic [fram_pkg::CMD_W-1:0]       op_r, op_nxt;
  logic [fram_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;

  // hold off the sender while reset is applied
  assign in_ready = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          op_nxt = in_command;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          fram_pkg::CMD_LOAD: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = fram_pkg::WSEL_IMM;
          end
          fram_pkg::CMD_MOVE: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = fram_pkg::WSEL_SRC;
          end
          fram_pkg::CMD_ADD: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = fram_pkg::WSEL_ADD;
          end
          fram_pkg::CMD_SUB: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = fram_pkg::WSEL_SUB;
          end
          fram_pkg::CMD_MUL: begin
            cmd.mul_init = 1'b1;
            cnt_nxt = fram_pkg::CNT_LAST;
            state_nxt = S_MUL;
          end
          fram_pkg::CMD_DIV: begin
            if (sts.src_zero) begin
              // error word; wait for room in the output register
              if (out_free) begin
                cmd.emit_err = 1'b1;
              end else begin
                state_nxt = S_EXEC;
              end
            end else begin
              cmd.div_init = 1'b1;
              cnt_nxt = fram_pkg::CNT_LAST;
              state_nxt = S_DIV;
            end
          end
          fram_pkg::CMD_OUT: begin
            if (out_free) begin
              cmd.emit_val = 1'b1;
            end else begin
              state_nxt = S_EXEC;
            end
          end
          default: begin
            // unused code: drop
          end
        endcase
      end
      S_MUL, S_DIV: begin
        cmd.mul_step = (state_r == S_MUL);
        cmd.div_step = (state_r == S_DIV);
        if (cnt_r == '0) begin
          state_nxt = S_WB;
        end else begin
          cnt_nxt = cnt_r - fram_pkg::CNT_W'(1);
        end
      end
      S_WB: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = (op_r == fram_pkg::CMD_MUL) ? fram_pkg::WSEL_MUL : fram_pkg::WSEL_DIV;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_val || cmd.emit_err) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      op_r <= op_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/core/fram_dp.sv
// Datapath: register file, adder, shift-and-add multiplier, restoring divider, output word.
`timescale 1ns / 1ps

module fram_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [fram_pkg::REG_AW-1:0]       in_dest_reg,
  input  logic [fram_pkg::REG_AW-1:0]       in_src_reg,
  input  logic signed [fram_pkg::IMM_W-1:0] in_immediate,
  output logic signed [fram_pkg::OUT_W-1:0] out_value,
  output logic                              out_div_zero_error,
  input  fram_pkg::fram_cmd_t               cmd,
  output fram_pkg::fram_sts_t               sts
);

  localparam int DW = fram_pkg::DATA_WIDTH;

  logic [fram_pkg::REG_AW-1:0]   dst_r, src_r;
  logic [DW-1:0]                 imm_r;
  logic [fram_pkg::NUM_REGS-1:0] valid_r;
  logic                          rv_d_r, rv_s_r;
  logic [DW-1:0]                 ram_d, ram_s;
  logic [DW-1:0]                 dv, sv;
  logic [DW-1:0]                 acc_r, acc_nxt;
  logic [DW-1:0]                 opa_r, opa_nxt;
  logic [DW-1:0]                 opb_r, opb_nxt;
  logic                          neg_r;
  logic [DW-1:0]                 wdata;
  logic [DW:0]                   div_sh, div_trial;
  logic signed [fram_pkg::OUT_W-1:0] out_value_r;
  logic                          err_r;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    mag = v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  fram_ram #(
    .WIDTH (DW),
    .DEPTH (fram_pkg::NUM_REGS)
  ) u_regs (
    .clk     (clk),
    .we      (cmd.wr_en),
    .waddr   (dst_r),
    .wdata   (wdata),
    .raddr_a (dst_r),
    .raddr_b (src_r),
    .rdata_a (ram_d),
    .rdata_b (ram_s)
  );

  // never-written registers read as zero
  assign dv = rv_d_r ? ram_d : '0;
  assign sv = rv_s_r ? ram_s : '0;
  assign sts.src_zero = (sv == '0);

  always_comb begin
    case (cmd.wr_sel)
      fram_pkg::WSEL_IMM: wdata = imm_r;
      fram_pkg::WSEL_SRC: wdata = sv;
      fram_pkg::WSEL_ADD: wdata = dv + sv;
      fram_pkg::WSEL_SUB: wdata = dv - sv;
      fram_pkg::WSEL_MUL: wdata = acc_r;
      fram_pkg::WSEL_DIV: wdata = neg_r ? (~opa_r + DW'(1)) : opa_r;
      default:            wdata = '0;
    endcase
  end

  assign div_sh = {acc_r, opa_r[DW-1]};
  assign div_trial = div_sh - {1'b0, opb_r};

  always_comb begin
    acc_nxt = acc_r;
    opa_nxt = opa_r;
    opb_nxt = opb_r;
    if (cmd.mul_init) begin
      acc_nxt = '0;
      opa_nxt = dv;
      opb_nxt = sv;
    end else if (cmd.div_init) begin
      acc_nxt = '0;
      opa_nxt = mag(dv);
      opb_nxt = mag(sv);
    end else if (cmd.mul_step) begin
      acc_nxt = opa_r[0] ? (acc_r + opb_r) : acc_r;
      opa_nxt = opa_r >> 1;
      opb_nxt = opb_r << 1;
    end else if (cmd.div_step) begin
      if (!div_trial[DW]) begin
        acc_nxt = div_trial[DW-1:0];
        opa_nxt = {opa_r[DW-2:0], 1'b1};
      end else begin
        acc_nxt = div_sh[DW-1:0];
        opa_nxt = {opa_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dst_r <= in_dest_reg;
      src_r <= in_src_reg;
      imm_r <= in_immediate[DW-1:0];
    end
    if (cmd.div_init) begin
      neg_r <= dv[DW-1] ^ sv[DW-1];
    end
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    rv_d_r <= valid_r[dst_r];
    rv_s_r <= valid_r[src_r];
    if (cmd.emit_val || cmd.emit_err) begin
      out_value_r <= cmd.emit_err ? '0 : fram_pkg::OUT_W'($signed(dv));
      err_r <= cmd.emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[dst_r] <= 1'b1;
    end
  end

  assign out_value = out_value_r;
  assign out_div_zero_error = err_r;

endmodule

### rtl/core/four_register_alu_machine_top.sv
// Top level of the four-register ALU machine: sequencer plus datapath.
`timescale 1ns / 1ps
// Load, move, add and sub write back in the execute state, which follows the read state;
// unused codes are dropped there. Out and divide-by-zero load the result word into the
// output register from the execute state, waiting there while that register is full.
// Mul and div run DATA_WIDTH shift steps, then write back. One word is taken at a time.
// Reset: synchronous, active low; all four registers read as zero and no result is pending.

module four_register_alu_machine_top (
  input  logic       clk,
  input  logic       rst_n,
  fram_in_if.sink    in_chan,
  fram_out_if.source out_chan
);

  // command and status bundles between sequencer and datapath
  fram_pkg::fram_cmd_t cmd;
  fram_pkg::fram_sts_t sts;

  // Sequencer: takes the instruction word, walks read, execute, iterate and
  // write-back, and owns the valid flag of the output register so a result
  // word can wait while the next instruction is already taken.
  fram_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_command (in_chan.command),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Datapath: four-entry register file with registered reads, add/sub,
  // one shared shift unit for multiply and divide, and the output word.
  fram_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_dest_reg        (in_chan.dest_reg),
    .in_src_reg         (in_chan.src_reg),
    .in_immediate       (in_chan.immediate),
    .out_value          (out_chan.out_value),
    .out_div_zero_error (out_chan.div_zero_error),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

### rtl/core/fram_chk.sv
// Port-level checker for the four-register ALU machine, bound to the top level.
`timescale 1ns / 1ps
`include "four_register_alu_machine_top_defines.svh"

module fram_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [fram_pkg::OUT_W-1:0] out_value,
  input logic                              out_div_zero_error
);

  `FRAM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_value), "result word changed while stalled")
  `FRAM_ASSERT(a_err_zero, clk, rst_n, out_valid && out_div_zero_error |-> out_value == '0, "error word carries nonzero value")
  `FRAM_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "second word taken while busy")
  `FRAM_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind four_register_alu_machine_top fram_chk u_fram_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_value          (out_chan.out_value),
  .out_div_zero_error (out_chan.div_zero_error)
);

### sim/four_register_alu_machine_top_tb.sv
// Self-checking testbench of the four-register ALU machine: instruction stream in, result words out.
`timescale 1ns / 1ps

module four_register_alu_machine_top_tb;

  localparam int DW = fram_pkg::DATA_WIDTH;
  localparam int CW = fram_pkg::CMD_W;
  localparam int AW = fram_pkg::REG_AW;
  localparam int IW = fram_pkg::IMM_W;
  localparam int OW = fram_pkg::OUT_W;

  // The unused command code: the machine drops it without a trace.
  localparam logic [CW-1:0] CMD_UNUSED = 3'd7;

  // Register indexes, A..D.
  localparam logic [AW-1:0] REG_A = 2'd0;
  localparam logic [AW-1:0] REG_B = 2'd1;
  localparam logic [AW-1:0] REG_C = 2'd2;
  localparam logic [AW-1:0] REG_D = 2'd3;

  // Corner immediates.
  localparam logic [IW-1:0] IMM_MAX = {1'b0, {(IW - 1){1'b1}}};
  localparam logic [IW-1:0] IMM_MIN = {1'b1, {(IW - 1){1'b0}}};
  localparam logic [IW-1:0] IMM_NEG1 = '1;

  // Run shape.
  localparam int RANDOM_PER_PHASE = 325;
  localparam int NUM_PHASES = 4;
  localparam int HOLD_CYCLES = 400;
  // Drain long enough for a trailing mul or div to finish.
  localparam int DRAIN_CYCLES = DW + 16;
  localparam int CYCLE_LIMIT = 1000000;

  // Idle and stall odds per phase, in percent: none, sender, receiver, both.
  localparam int SEND_IDLE[NUM_PHASES] = '{0, 63, 0, 18};
  localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 63, 18};

  typedef logic [DW-1:0] word_t;

  typedef struct packed {
    logic [CW-1:0] command;
    logic [AW-1:0] dest;
    logic [AW-1:0] src;
    logic [IW-1:0] imm;
  } instr_t;

  typedef struct packed {
    logic signed [OW-1:0] value;
    logic                 err;
  } result_t;

  logic clk;
  logic rst_n;

  fram_in_if in_chan ();
  fram_out_if out_chan ();

  four_register_alu_machine_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Instructions still to be offered, and result words the machine still owes.
  instr_t  instr_backlog[$];
  result_t out_words_due[$];

  // Predicted register file.
  word_t arch_regs[fram_pkg::NUM_REGS];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int cycle_count;

  // Receiver hold-off: the stimulus bumps the request count, the ready driver counts it down.
  int hold_requests;
  int hold_seen;
  int hold_left;

  // Set at the edge where the machine took the offered word.
  logic word_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: execute one instruction on the predicted registers.
  // Return 1 with the result word when the instruction emits one.
  // ---------------------------------------------------------------------------
  function automatic word_t magnitude(input word_t v);
    return v[DW-1] ? word_t'(-v) : v;
  endfunction

  function automatic bit retire_instruction(input instr_t w, output result_t res);
    word_t dv;
    word_t sv;
    word_t quo;
    logic signed [DW-1:0] shown;
    dv = arch_regs[w.dest];
    sv = arch_regs[w.src];
    res = '0;
    retire_instruction = 1'b0;
    case (w.command)
      fram_pkg::CMD_LOAD: arch_regs[w.dest] = w.imm[DW-1:0];
      fram_pkg::CMD_MOVE: arch_regs[w.dest] = sv;
      fram_pkg::CMD_ADD:  arch_regs[w.dest] = dv + sv;
      fram_pkg::CMD_SUB:  arch_regs[w.dest] = dv - sv;
      fram_pkg::CMD_MUL:  arch_regs[w.dest] = dv * sv;
      fram_pkg::CMD_DIV: begin
        if (sv == '0) begin
          // Divide by zero: leave the destination alone, flag the error.
          res.err = 1'b1;
          retire_instruction = 1'b1;
        end else begin
          // Divide magnitudes, then fix the sign: truncates toward zero, and
          // the most negative value over minus one wraps back to itself.
          quo = magnitude(dv) / magnitude(sv);
          if (dv[DW-1] != sv[DW-1]) quo = -quo;
          arch_regs[w.dest] = quo;
        end
      end
      fram_pkg::CMD_OUT: begin
        shown = dv;
        res.value = OW'(shown);
        retire_instruction = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_instr(input logic [CW-1:0] cmd, input logic [AW-1:0] dst,
                             input logic [AW-1:0] srcr, input logic [IW-1:0] imm);
    instr_t w;
    w.command = cmd;
    w.dest = dst;
    w.src = srcr;
    w.imm = imm;
    instr_backlog.push_back(w);
  endtask

  // Mix full-width noise with small values, zeros and the corners, so that
  // divides see zero divisors and non-trivial quotients.
  function automatic logic [IW-1:0] random_imm();
    int small_val;
    logic signed [IW-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = {$urandom, $urandom};
      2, 3: begin
        small_val = int'($urandom_range(0, 40)) - 20;
        v = IW'(small_val);
      end
      4: begin
        case ($urandom_range(0, 3))
          0: v = IMM_MAX;
          1: v = IMM_MIN;
          2: v = IMM_NEG1;
          default: v = IW'(1);
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic instr_t random_instr();
    instr_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 24) w.command = fram_pkg::CMD_LOAD;
    else if (pick < 30) w.command = fram_pkg::CMD_MOVE;
    else if (pick < 40) w.command = fram_pkg::CMD_ADD;
    else if (pick < 50) w.command = fram_pkg::CMD_SUB;
    else if (pick < 60) w.command = fram_pkg::CMD_MUL;
    else if (pick < 72) w.command = fram_pkg::CMD_DIV;
    else if (pick < 97) w.command = fram_pkg::CMD_OUT;
    else w.command = CMD_UNUSED;
    w.dest = AW'($urandom);
    w.src = AW'($urandom);
    // The immediate is noise for every command but load.
    w.imm = random_imm();
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the next instruction word at the falling edge. Hold the word
  // until it is taken, then advance or go idle at the odds of the phase.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_instructions
    instr_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || word_taken) begin
      if (instr_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = instr_backlog.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.command <= nxt.command;
        in_chan.dest_reg <= nxt.dest;
        in_chan.src_reg <= nxt.src;
        in_chan.immediate <= nxt.imm;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at the odds of the phase, or hold ready low for a long
  // stretch when asked so the machine backs up into its input.
  always @(negedge clk) begin : drive_ready
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge check a result word against the oldest due
  // word first, then predict the instruction word taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_words
    instr_t  seen;
    result_t got;
    result_t want;
    result_t due;
    word_taken <= rst_n && in_chan.valid === 1'b1 && in_chan.ready === 1'b1;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.value = out_chan.out_value;
      got.err = out_chan.div_zero_error;
      if (out_words_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got value %0d error %b",
                 $time, got.value, got.err);
        error_count++;
      end else begin
        want = out_words_due.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: out_value mismatch, expected %0d, got %0d",
                   $time, want.value, got.value);
          error_count++;
        end
        if (got.err !== want.err) begin
          $display("%0t: div_zero_error mismatch, expected %b, got %b",
                   $time, want.err, got.err);
          error_count++;
        end
      end
    end
    if (rst_n && in_chan.valid === 1'b1 && in_chan.ready === 1'b1) begin
      seen.command = in_chan.command;
      seen.dest = in_chan.dest_reg;
      seen.src = in_chan.src_reg;
      seen.imm = in_chan.immediate;
      if (retire_instruction(seen, due)) out_words_due.push_back(due);
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped by watchdog after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    // Drive every input to a known value from time zero.
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.command = fram_pkg::CMD_LOAD;
    in_chan.dest_reg = REG_A;
    in_chan.src_reg = REG_A;
    in_chan.immediate = '0;
    out_chan.ready = 1'b0;
    word_taken = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    cycle_count = 0;
    hold_requests = 0;
    hold_seen = 0;
    hold_left = 0;
    foreach (arch_regs[i]) arch_regs[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      @(posedge clk);
      send_idle_pct = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];

      if (phase == 0) begin
        // Corners into all four registers, then read them back.
        queue_instr(fram_pkg::CMD_LOAD, REG_A, REG_A, IMM_MAX);
        queue_instr(fram_pkg::CMD_LOAD, REG_B, REG_A, IMM_MIN);
        queue_instr(fram_pkg::CMD_LOAD, REG_C, REG_A, IMM_NEG1);
        queue_instr(fram_pkg::CMD_LOAD, REG_D, REG_A, '0);
        queue_instr(fram_pkg::CMD_OUT, REG_A, REG_A, '0);
        queue_instr(fram_pkg::CMD_OUT, REG_B, REG_A, '0);
        queue_instr(fram_pkg::CMD_OUT, REG_C, REG_A, '0);
        queue_instr(fram_pkg::CMD_OUT, REG_D, REG_A, '0);
        // Divide by zero: error word, destination kept.
        queue_instr(fram_pkg::CMD_DIV, REG_A, REG_D, '0);
        queue_instr(fram_pkg::CMD_OUT, REG_A, REG_A, '0);
        // Most negative over minus one wraps to itself.
        queue_instr(fram_pkg::CMD_DIV, REG_B, REG_C, '0);
        queue_instr(fram_pkg::CMD_OUT, REG_B, REG_A, '0);
        // Wrapping add, sub and mul.
        queue_instr(fram_pkg::CMD_ADD, REG_A, REG_A, '0);
        queue_instr(fram_pkg::CMD_SUB, REG_D, REG_B, '0);
        queue_instr(fram_pkg::CMD_OUT, REG_D, REG_A, '0);
        queue_instr(fram_pkg::CMD_MUL, REG_C, REG_C, '0);
        queue_instr(fram_pkg::CMD_MUL, REG_A, REG_B, '0);
        queue_instr(fram_pkg::CMD_OUT, REG_A, REG_A, '0);
        // Move, then a negative quotient that truncates toward zero.
        queue_instr(fram_pkg::CMD_MOVE, REG_A, REG_C, '0);
        queue_instr(fram_pkg::CMD_LOAD, REG_D, REG_A, IW'(-7));
        queue_instr(fram_pkg::CMD_LOAD, REG_B, REG_A, IW'(2));
        queue_instr(fram_pkg::CMD_DIV, REG_D, REG_B, '0);
        queue_instr(fram_pkg::CMD_OUT, REG_D, REG_A, '0);
        // Unused code: no change, no word.
        queue_instr(CMD_UNUSED, REG_A, REG_B, IMM_NEG1);
        queue_instr(fram_pkg::CMD_OUT, REG_A, REG_A, '0);
      end

      repeat (RANDOM_PER_PHASE) instr_backlog.push_back(random_instr());

      if (phase == 0) begin
        // Once the stream is flowing, hold the receiver off while the sender keeps going.
        while (instr_backlog.size() > RANDOM_PER_PHASE - 40) @(negedge clk);
        @(posedge clk);
        hold_requests = hold_requests + 1;
      end

      while (instr_backlog.size() != 0) @(negedge clk);
    end

    // Wait for the last word to be taken and every due result to arrive.
    while (in_chan.valid === 1'b1 || out_words_due.size() != 0) @(negedge clk);
    // Let a trailing mul or div finish so a stray word would still be caught.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
